[hw/rtl/pcm_voice_mixer_defines.svh]
// Assertion macros shared by the pcm voice mixer RTL.
`ifndef PCM_VOICE_MIXER_DEFINES_SVH
`define PCM_VOICE_MIXER_DEFINES_SVH

// Plain property, sampled on the block clock, idle during reset.
`define PVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define PVM_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

[hw/rtl/pvm_pkg.sv]
// Types, constants and codes for the pcm voice mixer.
package pvm_pkg;

  localparam int unsigned VOICES           = 16;
  localparam int unsigned SAMPLE_ADDR_BITS = 16;
  localparam int unsigned VB               = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned REG_DEPTH        = VOICES * 8;
  localparam int unsigned SAMPLE_DEPTH     = 1 << SAMPLE_ADDR_BITS;
  localparam logic [31:0] ADDR_BASE        = 32'h0040_0000;
  localparam logic [17:0] SAT_MAX          = 18'sd32767;
  localparam logic [17:0] SAT_MIN          = -18'sd32768;

  typedef enum logic [1:0] {
    OP_REG_WR    = 2'd0,
    OP_ENABLE_WR = 2'd1,
    OP_SAMPLE_WR = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  voice;
    logic [2:0]  register_index;
    logic [31:0] write_data;
    logic [15:0] sample_address;
    logic [7:0]  sample_byte;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_t;

  // Decoded per-voice state held in the voice state memory
  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] rbase;
    logic [31:0] start;
    logic [31:0] end_addr;
    logic [31:0] loop_addr;
    logic        loop_on;
    logic [15:0] lgain;
    logic [15:0] rgain;
    logic [15:0] step;
  } vstate_t;

  // Register words used by decode, already half-swapped
  typedef struct packed {
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [31:0] w5;
    logic [31:0] w7;
  } words_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_VOICE  = 9'b000000010,
    S_LOAD   = 9'b000000100,
    S_REG    = 9'b000001000,
    S_DECODE = 9'b000010000,
    S_CHECK  = 9'b000100000,
    S_MIX    = 9'b001000000,
    S_ACC    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

endpackage

[hw/rtl/pvm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pvm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/pvm_decode.sv]
// Voice decode: register words to start, end, loop, gains and step.
module pvm_decode (
  input  pvm_pkg::words_t  words_i,
  input  pvm_pkg::vstate_t old_i,
  output pvm_pkg::vstate_t new_o
);
  import pvm_pkg::*;

  logic        st_ok;
  logic [31:0] st;
  logic [31:0] la;

  assign st_ok = words_i.w1 > ADDR_BASE;
  assign st    = words_i.w1 - ADDR_BASE;
  assign la    = {words_i.w4[31:16], words_i.w3[31:16]};

  always_comb begin
    new_o = old_i;
    // start at or below the base clears the start address, else restart on change
    if (!st_ok) begin
      new_o.start = '0;
    end else if (st != old_i.start) begin
      new_o.start = st;
      new_o.rbase = st;
      new_o.pos   = '0;
    end
    new_o.end_addr = (words_i.w5 != '0) ? (words_i.w5 - ADDR_BASE) : '0;
    // loop point only taken when the loop flag word is set
    new_o.loop_on = words_i.w2[31:16] != '0;
    if (new_o.loop_on) begin
      if (la > ADDR_BASE) begin
        new_o.loop_addr = la - ADDR_BASE;
      end else begin
        new_o.loop_addr = la;
        new_o.loop_on   = 1'b0;
      end
    end
    new_o.lgain = words_i.w7[15:0];
    new_o.rgain = words_i.w7[31:16];
    new_o.step  = words_i.w3[15:0];
  end

endmodule

[hw/rtl/pcm_voice_mixer.sv]
// Top level of the pcm voice mixer: command sequencer, voice walk and mixer.
// Usage: one input channel carries command words (voice register write,
// enable mask write, sample byte write, tick). Writes give no result. A tick
// walks the voices in order and gives one output word holding the saturated
// left and right mix.
// Per voice a tick passes only S_VOICE when the voice is disabled, goes on
// through S_LOAD and S_CHECK when it is enabled but silent, and adds S_MIX and
// S_ACC when playing; a voice that needs decoding also reads its register
// words in S_LOAD and S_REG and decodes them in S_DECODE. The register and
// voice state memories each have a single read port, so register words are
// read one after another.
// Per-voice state sits in a voice state memory and is read, updated and
// written back once per voice; no two accesses to one entry overlap.
// Reset clears all control flags and valid bits: unwritten register words and
// never-stored voice state read as zero, with no clearing pass.
// Sample memory contents are undefined until written.
// The result sits in an output register; while the receiver stalls, write
// commands are still taken, and a further tick holds at its end until the
// earlier result is taken.
module pcm_voice_mixer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pvm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pvm_pkg::out_t  out_data_o
);
  import pvm_pkg::*;

  localparam int unsigned RAW = VB + 3;
  localparam int unsigned VSW = $bits(vstate_t);

  state_e            state_q, state_d;
  logic [VB-1:0]     vi_q, vi_d;
  logic [2:0]        k_q, k_d;
  logic [VOICES-1:0] en_q, en_d, dec_q, dec_d, play_q, play_d;
  logic [VOICES-1:0] stv_q, stv_d, pclr_q, pclr_d;
  logic [REG_DEPTH-1:0] rv_q, rv_d;
  logic [31:0]       w_q [8];
  vstate_t           vs_q, vs_d, dec_new;
  logic signed [15:0] accl_q, accl_d, accr_q, accr_d;
  logic signed [23:0] prodl_q, prodr_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              accept;
  op_e               op;
  logic              last;

  // memory ports
  logic              reg_we, reg_re;
  logic [RAW-1:0]    reg_waddr, reg_raddr;
  logic [31:0]       reg_rdata;
  logic              st_we, st_re;
  logic [VSW-1:0]    st_wdata, st_rdata;
  logic              smp_we, smp_re;
  logic [SAMPLE_ADDR_BITS-1:0] smp_waddr, smp_raddr;
  logic [7:0]        smp_rdata;

  logic [31:0]       rd_addr;
  logic [31:0]       pos_new, cmp_addr;
  logic signed [17:0] sum_l, sum_r;
  words_t            words;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = state_q == S_IDLE;
  assign op         = op_e'(in_data_i.operation);
  assign last       = vi_q == VB'(VOICES - 1);

  assign reg_waddr = {in_data_i.voice[VB-1:0], in_data_i.register_index};
  assign smp_waddr = SAMPLE_ADDR_BITS'(in_data_i.sample_address);
  assign rd_addr   = (vs_q.pos >> 12) + vs_q.rbase;
  assign smp_raddr = rd_addr[SAMPLE_ADDR_BITS-1:0];

  assign words = '{w1: w_q[1], w2: w_q[2], w3: w_q[3], w4: w_q[4],
                   w5: w_q[5], w7: w_q[7]};

  pvm_ram #(.WIDTH(32), .DEPTH(REG_DEPTH)) u_reg_ram (
    .clk_i, .we_i(reg_we), .waddr_i(reg_waddr),
    .wdata_i({in_data_i.write_data[15:0], in_data_i.write_data[31:16]}),
    .re_i(reg_re), .raddr_i(reg_raddr), .rdata_o(reg_rdata)
  );

  pvm_ram #(.WIDTH(VSW), .DEPTH(VOICES)) u_state_ram (
    .clk_i, .we_i(st_we), .waddr_i(vi_q), .wdata_i(st_wdata),
    .re_i(st_re), .raddr_i(vi_q), .rdata_o(st_rdata)
  );

  pvm_ram #(.WIDTH(8), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk_i, .we_i(smp_we), .waddr_i(smp_waddr), .wdata_i(in_data_i.sample_byte),
    .re_i(smp_re), .raddr_i(smp_raddr), .rdata_o(smp_rdata)
  );

  pvm_decode u_decode (
    .words_i(words), .old_i(vs_q), .new_o(dec_new)
  );

  // mix arithmetic: floor shift and add; next sample position and its read address
  always_comb begin
    sum_l    = 18'(accl_q) + 18'($signed(prodl_q[23:8]));
    sum_r    = 18'(accr_q) + 18'($signed(prodr_q[23:8]));
    pos_new  = vs_q.pos + 32'(vs_q.step);
    cmp_addr = (pos_new >> 12) + vs_q.rbase;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    vi_d     = vi_q;
    k_d      = k_q;
    en_d     = en_q;
    dec_d    = dec_q;
    play_d   = play_q;
    stv_d    = stv_q;
    pclr_d   = pclr_q;
    rv_d     = rv_q;
    vs_d     = vs_q;
    accl_d   = accl_q;
    accr_d   = accr_q;
    reg_we   = 1'b0;
    reg_re   = 1'b0;
    reg_raddr = {vi_q, k_q};
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_wdata = vs_q;
    smp_we   = 1'b0;
    smp_re   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_REG_WR: begin
              if ({1'b0, in_data_i.voice} < 5'(VOICES)) begin
                reg_we = 1'b1;
                rv_d[reg_waddr] = 1'b1;
                dec_d[in_data_i.voice[VB-1:0]] = 1'b0;
              end
            end
            OP_ENABLE_WR: begin
              for (int v = 0; v < VOICES; v++) begin
                if (in_data_i.write_data[16+v] != en_q[v]) begin
                  if (en_q[v]) begin
                    pclr_d[v] = 1'b1;
                  end
                  en_d[v]   = in_data_i.write_data[16+v];
                  play_d[v] = 1'b0;
                  dec_d[v]  = 1'b0;
                end
              end
            end
            OP_SAMPLE_WR: begin
              smp_we = 1'b1;
            end
            OP_TICK: begin
              vi_d    = '0;
              accl_d  = '0;
              accr_d  = '0;
              state_d = S_VOICE;
            end
            default: ;
          endcase
        end
      end
      S_VOICE: begin
        if (en_q[vi_q]) begin
          st_re     = 1'b1;
          reg_re    = 1'b1;
          reg_raddr = {vi_q, 3'd1};
          k_d       = 3'd1;
          state_d   = S_LOAD;
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          vi_d = vi_q + 1'b1;
        end
      end
      S_LOAD: begin
        vs_d = stv_q[vi_q] ? vstate_t'(st_rdata) : '0;
        if (pclr_q[vi_q]) begin
          vs_d.pos = '0;
        end
        if (dec_q[vi_q]) begin
          state_d = S_CHECK;
        end else begin
          reg_re    = 1'b1;
          reg_raddr = {vi_q, k_q + 3'd1};
          k_d       = k_q + 3'd1;
          state_d   = S_REG;
        end
      end
      S_REG: begin
        if (k_q == 3'd7) begin
          state_d = S_DECODE;
        end else begin
          reg_re    = 1'b1;
          reg_raddr = {vi_q, k_q + 3'd1};
          k_d       = k_q + 3'd1;
        end
      end
      S_DECODE: begin
        vs_d          = dec_new;
        dec_d[vi_q]   = 1'b1;
        play_d[vi_q]  = (dec_new.start != '0) && (dec_new.step != '0);
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (play_q[vi_q]) begin
          smp_re  = 1'b1;
          state_d = S_MIX;
        end else begin
          st_we        = 1'b1;
          stv_d[vi_q]  = 1'b1;
          pclr_d[vi_q] = 1'b0;
          if (last) begin
            state_d = S_DONE;
          end else begin
            vi_d    = vi_q + 1'b1;
            state_d = S_VOICE;
          end
        end
      end
      S_MIX: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        accl_d = (sum_l > $signed(SAT_MAX)) ? 16'sh7fff :
                 (sum_l < $signed(SAT_MIN)) ? 16'sh8000 : sum_l[15:0];
        accr_d = (sum_r > $signed(SAT_MAX)) ? 16'sh7fff :
                 (sum_r < $signed(SAT_MIN)) ? 16'sh8000 : sum_r[15:0];
        vs_d.pos = pos_new;
        if (cmp_addr >= vs_q.end_addr) begin
          if (vs_q.loop_on) begin
            vs_d.rbase = vs_q.loop_addr;
            vs_d.pos   = '0;
          end else begin
            play_d[vi_q] = 1'b0;
          end
        end
        st_we        = 1'b1;
        st_wdata     = vs_d;
        stv_d[vi_q]  = 1'b1;
        pclr_d[vi_q] = 1'b0;
        if (last) begin
          state_d = S_DONE;
        end else begin
          vi_d    = vi_q + 1'b1;
          state_d = S_VOICE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vi_q        <= '0;
      k_q         <= '0;
      en_q        <= '0;
      dec_q       <= '0;
      play_q      <= '0;
      stv_q       <= '0;
      pclr_q      <= '0;
      rv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vi_q    <= vi_d;
      k_q     <= k_d;
      en_q    <= en_d;
      dec_q   <= dec_d;
      play_q  <= play_d;
      stv_q   <= stv_d;
      pclr_q  <= pclr_d;
      rv_q    <= rv_d;
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    vs_q   <= vs_d;
    accl_q <= accl_d;
    accr_q <= accr_d;
    if (state_q == S_LOAD || state_q == S_REG) begin
      w_q[k_q] <= rv_q[{vi_q, k_q}] ? reg_rdata : '0;
    end
    if (state_q == S_MIX) begin
      prodl_q <= 24'($signed(smp_rdata) * $signed(vs_q.lgain));
      prodr_q <= 24'($signed(smp_rdata) * $signed(vs_q.rgain));
    end
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.left_sample  <= accl_q;
      out_q.right_sample <= accr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "pcm_voice_mixer_defines.svh"

  `PVM_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result word not from end of tick")
  `PVM_ASSERT_IMP(a_reg_wr_idle, reg_we, state_q == S_IDLE, "register write during tick")
  `PVM_ASSERT_IMP(a_st_wr_state, st_we, state_q == S_CHECK || state_q == S_ACC, "stray voice state write")
  `PVM_ASSERT(a_play_enabled, (play_q & ~en_q) == '0, "voice playing while disabled")

endmodule

[bench/pcm_voice_mixer_checker.sv]
// Checker for the pcm voice mixer: watches both channels, predicts each mix word and compares.
module pcm_voice_mixer_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  pvm_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  pvm_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            mixes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pvm_pkg::*;

  localparam int NV = 16;

  // Predictor state
  logic [31:0] regs_q [NV*8];
  bit          en_q [NV];
  bit          dec_q [NV];
  bit          play_q [NV];
  logic [31:0] pos_q [NV];
  logic [31:0] rbase_q [NV];
  logic [31:0] start_q [NV];
  logic [31:0] end_q [NV];
  logic [31:0] loop_q [NV];
  bit          loop_on_q [NV];
  logic [15:0] lgain_q [NV];
  logic [15:0] rgain_q [NV];
  logic [15:0] step_q [NV];
  logic [7:0]  smem_q [SAMPLE_DEPTH];

  out_t expected_mix_q[$];
  int   fails = 0;
  int   seen = 0;
  int   pending_q = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_q;
  assign mixes_seen_o = seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fails++;
  endtask

  function automatic int clamp16(input int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  task automatic decode_voice(input int v);
    logic [31:0] st, la;
    st = regs_q[v*8+1];
    if (st > ADDR_BASE) st = st - ADDR_BASE;
    else begin
      st = 0;
      start_q[v] = 0;
    end
    end_q[v] = regs_q[v*8+5];
    if (end_q[v] != 0) end_q[v] = end_q[v] - ADDR_BASE;
    loop_on_q[v] = (regs_q[v*8+2] >> 16) != 0;
    if (loop_on_q[v]) begin
      la = (regs_q[v*8+4] & 32'hffff0000) | (regs_q[v*8+3] >> 16);
      loop_q[v] = la;
      if (la > ADDR_BASE) loop_q[v] = la - ADDR_BASE;
      else loop_on_q[v] = 0;
    end
    lgain_q[v] = regs_q[v*8+7][15:0];
    rgain_q[v] = regs_q[v*8+7][31:16];
    step_q[v]  = regs_q[v*8+3][15:0];
    if (st != start_q[v]) begin
      rbase_q[v] = st;
      start_q[v] = st;
      pos_q[v]   = 0;
    end
    dec_q[v]  = 1;
    play_q[v] = start_q[v] != 0 && step_q[v] != 0;
  endtask

  // Apply one accepted command word; a tick yields the expected mix
  task automatic apply_command(input in_t c);
    int l, r, s, pl, pr;
    logic [15:0] mask;
    logic [31:0] d;
    out_t m;
    l = 0;
    r = 0;
    d = c.write_data;
    case (op_e'(c.operation))
      OP_REG_WR: begin
        regs_q[c.voice*8+c.register_index] = {d[15:0], d[31:16]};
        dec_q[c.voice] = 0;
      end
      OP_ENABLE_WR: begin
        mask = d[31:16];
        for (int i = 0; i < NV; i++) begin
          if (mask[i] != en_q[i]) begin
            if (en_q[i]) pos_q[i] = 0;
            en_q[i]   = mask[i];
            play_q[i] = 0;
            dec_q[i]  = 0;
          end
        end
      end
      OP_SAMPLE_WR: smem_q[c.sample_address] = c.sample_byte;
      default: begin
        for (int i = 0; i < NV; i++) begin
          if (!en_q[i]) continue;
          if (!dec_q[i]) decode_voice(i);
          if (!play_q[i]) continue;
          s = $signed(smem_q[16'((pos_q[i] >> 12) + rbase_q[i])]);
          pl = s * $signed(lgain_q[i]);
          pr = s * $signed(rgain_q[i]);
          l = clamp16(l + (pl >>> 8));
          r = clamp16(r + (pr >>> 8));
          pos_q[i] = pos_q[i] + step_q[i];
          if ((pos_q[i] >> 12) + rbase_q[i] >= end_q[i]) begin
            if (loop_on_q[i]) begin
              rbase_q[i] = loop_q[i];
              pos_q[i]   = 0;
            end else play_q[i] = 0;
          end
        end
        m.left_sample  = l[15:0];
        m.right_sample = r[15:0];
        expected_mix_q.push_back(m);
      end
    endcase
  endtask

  initial begin
    for (int i = 0; i < NV*8; i++) regs_q[i] = '0;
    for (int i = 0; i < NV; i++) begin
      en_q[i] = 0; dec_q[i] = 0; play_q[i] = 0; pos_q[i] = 0; rbase_q[i] = 0;
      start_q[i] = 0; end_q[i] = 0; loop_q[i] = 0; loop_on_q[i] = 0;
      lgain_q[i] = 0; rgain_q[i] = 0; step_q[i] = 0;
    end
    for (int i = 0; i < SAMPLE_DEPTH; i++) smem_q[i] = '0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        seen <= seen + 1;
        if (expected_mix_q.size() == 0)
          report_mismatch("mix word with nothing expected");
        else begin
          e = expected_mix_q.pop_front();
          if (out_data_i.left_sample !== e.left_sample)
            report_mismatch($sformatf("left %0d, expected %0d",
                            out_data_i.left_sample, e.left_sample));
          if (out_data_i.right_sample !== e.right_sample)
            report_mismatch($sformatf("right %0d, expected %0d",
                            out_data_i.right_sample, e.right_sample));
        end
      end
      if (in_valid_i && in_ready_i) apply_command(in_data_i);
      pending_q <= expected_mix_q.size();
    end
  end
endmodule

[bench/tb.sv]
// Testbench top for the pcm voice mixer: command stimulus, idling and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pvm_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 160;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  in_valid_i = 0;
  logic  in_ready_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 0;
  out_t  out_data_o;
  int    fail_count, pending, mixes_seen;
  int    idle_cycles = 0;
  int    ticks_sent = 0;
  bit    stim_done = 0;
  // Sample bytes known to be written; reads only hit these
  bit    written [SAMPLE_DEPTH];

  always #10 clk_i = ~clk_i;

  pcm_voice_mixer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  pcm_voice_mixer_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .mixes_seen_o(mixes_seen)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("tb failed");
      $finish;
    end
  end

  // Receiver stalls; bursts without stalls in some windows
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (stim_done || ($urandom_range(0, 3) == 0)) out_ready_i <= 1;
      else begin
        g = gap_len();
        out_ready_i <= (g == 0);
        repeat (g) @(negedge clk_i);
        out_ready_i <= 1;
      end
    end
  end

  // Ready is steady at the falling edge, so it tells whether the next rising edge accepts
  task automatic send(input in_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    in_data_i  <= c;
    in_valid_i <= 1;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    if (c.operation == OP_TICK) ticks_sent++;
  endtask

  task automatic send_op(input op_e op, input logic [3:0] v, input logic [2:0] idx,
                         input logic [31:0] d, input logic [15:0] a, input logic [7:0] b);
    in_t c;
    c.operation = op;
    c.voice = v;
    c.register_index = idx;
    c.write_data = d;
    c.sample_address = a;
    c.sample_byte = b;
    if (op == OP_SAMPLE_WR) written[a] = 1;
    send(c);
  endtask

  // Register words go in half-swapped, so write the swap of the wanted stored word
  task automatic put_word(input logic [3:0] v, input logic [2:0] idx, input logic [31:0] w);
    send_op(OP_REG_WR, v, idx, {w[15:0], w[31:16]}, $urandom, $urandom);
  endtask

  // Fill a region with random bytes
  task automatic fill(input logic [15:0] base, input int n);
    for (int k = 0; k < n; k++)
      send_op(OP_SAMPLE_WR, $urandom, $urandom, $urandom, base + 16'(k), $urandom);
  endtask

  // Program a voice to play within a filled region [base, base+len)
  task automatic program_voice(input logic [3:0] v, input logic [15:0] base, input int len,
                               input bit looping, input logic [31:0] gains,
                               input logic [15:0] stp);
    logic [15:0] lp;
    lp = base + 16'($urandom_range(0, len / 2));
    put_word(v, 1, ADDR_BASE + base);
    put_word(v, 5, ADDR_BASE + base + len);
    put_word(v, 2, looping ? 32'h0001_0000 : $urandom_range(0, 16'hffff));
    put_word(v, 3, {lp, stp});
    put_word(v, 4, 32'h0040_0000);
    put_word(v, 7, gains);
  endtask

  task automatic tick();
    send_op(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int r;
    logic [15:0] mask;
    for (int i = 0; i < SAMPLE_DEPTH; i++) written[i] = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: all-zero ticks, extreme bytes and gains, wrap at top of memory
    tick();
    send_op(OP_SAMPLE_WR, 0, 0, 0, 16'h0000, 8'h7f);
    send_op(OP_SAMPLE_WR, 0, 0, 0, 16'hffff, 8'h80);
    fill(16'h0100, 8);
    fill(16'hfff8, 7);
    program_voice(0, 16'h0100, 8, 1, 32'h7fff_8000, 16'hffff);
    program_voice(15, 16'hfff8, 8, 0, 32'h8000_7fff, 16'h1000);
    put_word(15, 5, ADDR_BASE + 32'h1_0008);           // end past top: read wraps to 0
    put_word(1, 1, 32'h0040_0000);                     // start at base: silent voice
    send_op(OP_REG_WR, 0, 6, 32'hffff_ffff, 0, 0);
    send_op(OP_ENABLE_WR, 0, 0, 32'hffff_ffff, 0, 0);
    repeat (4) tick();
    send_op(OP_ENABLE_WR, 0, 0, 32'h8001_0000, 0, 0);
    repeat (3) tick();
    send_op(OP_ENABLE_WR, 0, 0, 32'h0000_ffff, 0, 0);
    tick();

    // Hold off until every mix word has come back
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);

    // Random: many loud voices saturate; mostly valid programs, some noise.
    // The filled region also covers reads just past an end address.
    fill(16'h2000, 128);
    for (int v = 0; v < 16; v++)
      program_voice(v, 16'h2000 + 16'(4 * v), 32, $urandom_range(0, 1),
                    $urandom, $urandom_range(1, 16'h3000));
    send_op(OP_ENABLE_WR, 0, 0, {16'hffff, 16'($urandom)}, 0, 0);
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 60) tick();
      else if (r < 75) program_voice($urandom, 16'h2000 + 16'($urandom_range(0, 32)), 32,
                                     $urandom_range(0, 1), $urandom, $urandom);
      else if (r < 85) begin
        mask = $urandom;
        send_op(OP_ENABLE_WR, 0, 0, {mask, 16'($urandom)}, 0, 0);
      end else if (r < 93)
        send_op(OP_SAMPLE_WR, 0, 0, 0, 16'h2000 + 16'($urandom_range(0, 63)), $urandom);
      else
        // stray register word that keeps reads inside written bytes
        put_word($urandom, 6, $urandom);
    end

    in_valid_i <= 0;
    stim_done = 1;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    $display("sent %0d ticks with random voice programs, masks and sample writes", ticks_sent);
    $display("checked %0d mix words", mixes_seen);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
